// ===== rtl/shp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shp_pkg: shared types and function of the 3x3 sharpen filter
// Field widths, register indexes, the result item record and the per-channel
// sharpen arithmetic.
// ---------------------------------------------------------------------------
package shp_pkg;

  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 4;
  localparam int PIX_W    = CHAN_W * NUM_CHAN;
  localparam int ROW_W    = 12;
  localparam int COL_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_CHAN_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t centre;
    pixel_t left;
    pixel_t right;
    pixel_t upper;
    pixel_t lower;
  } nbhd_t;

  // Pending bits: 0 the centre result, 1 the last-column border result,
  // 2 the last-row border result, 3 the bottom-right corner.
  typedef struct packed {
    logic [3:0]                          pending;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]     vals;
    logic [ROW_W-1:0]                    row_main;
    logic [ROW_W-1:0]                    row_last;
    logic [COL_W-1:0]                    col_main;
    logic [COL_W-1:0]                    col_last;
  } item_t;

  function automatic logic [CHAN_W-1:0] sharpen(
    input logic [CHAN_W-1:0] centre,
    input logic [CHAN_W-1:0] left,
    input logic [CHAN_W-1:0] right,
    input logic [CHAN_W-1:0] upper,
    input logic [CHAN_W-1:0] lower
  );
    logic signed [11:0] acc;
    logic [CHAN_W-1:0]  res;
    acc = 12'({centre, 2'b00}) + 12'(centre) - 12'(left) - 12'(right)
        - 12'(upper) - 12'(lower);
    if (acc < 0) begin
      res = '0;
    end else if (acc > 12'sd255) begin
      res = '1;
    end else begin
      res = acc[CHAN_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/shp_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shp_if: stream interfaces of the 3x3 sharpen filter
// Pixel input channel and result output channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface shp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_a;
  logic [7:0] chan_b;
  logic [7:0] chan_c;
  logic [7:0] chan_d;

  modport source (output valid, output chan_a, output chan_b, output chan_c,
                  output chan_d, input ready);
  modport sink (input valid, input chan_a, input chan_b, input chan_c,
                input chan_d, output ready);
endinterface

interface shp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  res_a;
  logic [7:0]  res_b;
  logic [7:0]  res_c;
  logic [7:0]  res_d;
  logic [11:0] out_row;
  logic [10:0] out_col;
  logic        run_end;

  modport source (output valid, output res_a, output res_b, output res_c,
                  output res_d, output out_row, output out_col, output run_end,
                  input ready);
  modport sink (input valid, input res_a, input res_b, input res_c,
                input res_d, input out_row, input out_col, input run_end,
                output ready);
endinterface

// ===== rtl/sharpen_3x3_filter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sharpen_3x3_filter: 3x3 Laplacian sharpen on a raster pixel stream
// Line stores, neighbourhood window, kernel and result sequencing.
// ---------------------------------------------------------------------------
// Pixels are taken in raster order at one per clock while the result register
// takes their results. The pixel at row r and column c completes the result
// for (r-1, c-1), which leaves via the pixel stage and result registers.
// Pixels in the last column or row, but for the first of each, also give the
// border results of that column or row, so such a pixel gives two to four
// results; the result register hands out one per clock while the output is
// ready, and input is held until the last is taken. The line stores have no
// clearing pass; the first two rows of each frame give only border results.
module sharpen_3x3_filter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [shp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [shp_pkg::CFG_DATA_W-1:0]    cfg_data,
  shp_in_if.sink                            pixels,
  shp_out_if.source                         results
);
  import shp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CFG_WIDTH_W-1:0]  cfg_width;
  logic [CFG_HEIGHT_W-1:0] cfg_height;
  logic [CFG_CHAN_W-1:0]   cfg_chan;
  logic [WW-1:0]           eff_w;
  logic [HW-1:0]           eff_h;

  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count_next;
  logic [RW-1:0] row_count_next;
  logic [CW-1:0] c_pre;
  logic [RW-1:0] r_pre;
  logic [HW-1:0] r_tmp;
  logic [WW-1:0] c_inc;
  logic [HW-1:0] r_inc;

  logic          accept;
  logic          s1_valid;
  logic          s1_adv;
  pixel_t        s1_px;
  logic [CW-1:0] s1_c;
  logic [RW-1:0] s1_r;

  pixel_t        top_rd;
  pixel_t        mid_rd;
  pixel_t        win [6];

  logic          main_res;
  logic          interior;
  logic          col_edge;
  logic          row_edge;
  nbhd_t         nbhd;
  item_t         item;
  logic          load_ready;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] vals;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= CFG_WIDTH_W'(640);
      cfg_height <= CFG_HEIGHT_W'(480);
      cfg_chan   <= CFG_CHAN_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   cfg_width  <= cfg_data[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:  cfg_height <= cfg_data[CFG_HEIGHT_W-1:0];
        REG_CHANNEL_COUNT: cfg_chan   <= cfg_data[CFG_CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(cfg_width) < 32'd3) begin
      eff_w = WW'(3);
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg_width);
    end
    if (32'(cfg_height) < 32'd3) begin
      eff_h = HW'(3);
    end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(cfg_height);
    end
  end

  // Position of the incoming pixel, allowing for a geometry change between
  // frames that leaves the counters beyond the new size.
  always_comb begin
    if (WW'(col_count) >= eff_w) begin
      c_pre = '0;
      r_tmp = HW'(row_count) + HW'(1);
    end else begin
      c_pre = col_count;
      r_tmp = HW'(row_count);
    end
    r_pre = (r_tmp >= eff_h) ? '0 : RW'(r_tmp);
    c_inc = WW'(c_pre) + WW'(1);
    r_inc = HW'(r_pre) + HW'(1);
    if (c_inc >= eff_w) begin
      col_count_next = '0;
      row_count_next = (r_inc >= eff_h) ? '0 : RW'(r_inc);
    end else begin
      col_count_next = CW'(c_inc);
      row_count_next = r_pre;
    end
  end

  assign s1_adv       = s1_valid && load_ready;
  assign pixels.ready = !s1_valid || s1_adv;
  assign accept       = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (accept) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
        s1_valid  <= 1'b1;
      end else if (s1_adv) begin
        s1_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px <= {pixels.chan_d, pixels.chan_c, pixels.chan_b, pixels.chan_a};
      s1_c  <= c_pre;
      s1_r  <= r_pre;
    end
  end

  shp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_line (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_c),
    .wdata (mid_rd),
    .re    (accept),
    .raddr (c_pre),
    .rdata (top_rd)
  );

  shp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_line (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_c),
    .wdata (s1_px),
    .re    (accept),
    .raddr (c_pre),
    .rdata (mid_rd)
  );

  // Window: entries 0 to 2 are column c-1 (top, middle, bottom), 3 to 5 are
  // column c-2.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_adv) begin
      win[3] <= win[0];
      win[4] <= win[1];
      win[5] <= win[2];
      win[0] <= top_rd;
      win[1] <= mid_rd;
      win[2] <= s1_px;
    end
  end

  assign main_res = (s1_r != '0) && (s1_c != '0);
  assign interior = (s1_r >= RW'(2)) && (s1_c >= CW'(2));
  assign col_edge = main_res && (WW'(s1_c) == eff_w - WW'(1));
  assign row_edge = main_res && (HW'(s1_r) == eff_h - HW'(1));

  assign nbhd.centre = win[1];
  assign nbhd.left   = win[4];
  assign nbhd.right  = mid_rd;
  assign nbhd.upper  = win[0];
  assign nbhd.lower  = win[2];

  shp_kernel u_kernel (
    .nbhd       (nbhd),
    .interior   (interior),
    .chan_count (cfg_chan),
    .vals       (vals)
  );

  assign item.pending  = {col_edge && row_edge, row_edge, col_edge, main_res};
  assign item.vals     = vals;
  assign item.row_main = ROW_W'(s1_r - RW'(1));
  assign item.row_last = ROW_W'(s1_r);
  assign item.col_main = COL_W'(s1_c - CW'(1));
  assign item.col_last = COL_W'(s1_c);

  shp_out_seq u_out_seq (
    .clk        (clk),
    .rst        (rst),
    .load       (s1_adv),
    .item       (item),
    .load_ready (load_ready),
    .results    (results)
  );

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_c) && $stable(s1_r))
    else $error("Stalled pixel stage lost its position.");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> WW'(col_count) < $past(eff_w))
    else $error("Column counter left the row.");

  a_corner_item: assert property (@(posedge clk) disable iff (rst)
    s1_adv && item.pending[3] |-> item.pending[2] && item.pending[1])
    else $error("Corner result without both border results.");

  a_border_needs_main: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (item.pending[1] || item.pending[2]) |-> item.pending[0])
    else $error("Border result without a centre result.");

endmodule

// ===== rtl/shp_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shp_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module shp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/shp_kernel.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shp_kernel: Laplacian sharpen of one neighbourhood, zero off the interior
// Four lanes: 5*centre minus four neighbours, clamped to 0..255; zero unused.
// ---------------------------------------------------------------------------
module shp_kernel (
  input  shp_pkg::nbhd_t                                       nbhd,
  input  logic                                                 interior,
  input  logic [shp_pkg::CFG_CHAN_W-1:0]                       chan_count,
  output logic [shp_pkg::NUM_CHAN-1:0][shp_pkg::CHAN_W-1:0]    vals
);
  import shp_pkg::*;

  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_lane
    always_comb begin
      if (interior && (CFG_CHAN_W'(k) < chan_count)) begin
        vals[k] = sharpen(nbhd.centre[k*CHAN_W +: CHAN_W],
                          nbhd.left[k*CHAN_W +: CHAN_W],
                          nbhd.right[k*CHAN_W +: CHAN_W],
                          nbhd.upper[k*CHAN_W +: CHAN_W],
                          nbhd.lower[k*CHAN_W +: CHAN_W]);
      end else begin
        vals[k] = '0;
      end
    end
  end

endmodule

// ===== rtl/shp_out_seq.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shp_out_seq: result register and sequencer
// Holds one pixel's results; hands out one transaction a cycle while ready.
// ---------------------------------------------------------------------------
module shp_out_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  shp_pkg::item_t  item,
  output logic            load_ready,
  shp_out_if.source       results
);
  import shp_pkg::*;

  logic [3:0] pending;
  logic [3:0] pending_next;
  item_t      held;
  logic [3:0] cur;
  logic       take;
  logic       last;

  assign cur        = pending & (~pending + 4'd1);
  assign take       = results.valid && results.ready;
  assign last       = (pending & ~cur) == 4'd0;
  assign load_ready = (pending == 4'd0) || (take && last);

  always_comb begin
    pending_next = pending;
    if (load && load_ready) begin
      pending_next = item.pending;
    end else if (take) begin
      pending_next = pending & ~cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      held <= item;
    end
  end

  assign results.valid   = pending != 4'd0;
  assign results.res_a   = cur[0] ? held.vals[0] : '0;
  assign results.res_b   = cur[0] ? held.vals[1] : '0;
  assign results.res_c   = cur[0] ? held.vals[2] : '0;
  assign results.res_d   = cur[0] ? held.vals[3] : '0;
  assign results.out_row = (cur[0] || cur[1]) ? held.row_main : held.row_last;
  assign results.out_col = (cur[0] || cur[2]) ? held.col_main : held.col_last;
  assign results.run_end = last;

endmodule

// ===== bench/sharpen_result_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sharpen_result_checker: predicts and checks the 3x3 sharpen filter output
// Follows the register writes and every accepted pixel transaction, keeps
// its own line stores, window and raster position, and queues the results
// each pixel must cause. Every accepted result transaction is compared field
// by field with the oldest queued result.
// ---------------------------------------------------------------------------
module sharpen_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [shp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shp_pkg::CFG_DATA_W-1:0] cfg_data,
  shp_in_if                              pix,
  shp_out_if                             res,
  output int                             failures,
  output int                             pixels_seen,
  output int                             queued
);
  import shp_pkg::*;

  localparam int LINE_DEPTH = 2048;
  localparam int ROWS_MAX   = 4096;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chans_t;

  typedef struct {
    chans_t           chans;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } sharp_result_t;

  pixel_t        older_row [LINE_DEPTH];
  pixel_t        newer_row [LINE_DEPTH];
  pixel_t        win_px [6];
  int            cur_row;
  int            cur_col;
  int            cfg_width;
  int            cfg_height;
  int            cfg_chans;
  sharp_result_t sharpened_q [$];

  function automatic int clamp_dim(int v, int hi);
    return (v < 3) ? 3 : ((v > hi) ? hi : v);
  endfunction

  function automatic sharp_result_t make_result(int r, int c, chans_t chans);
    sharp_result_t item;
    item.chans = chans;
    item.row   = ROW_W'(r);
    item.col   = COL_W'(c);
    item.last  = 1'b0;
    return item;
  endfunction

  task automatic predict_pixel(input pixel_t px);
    int            w;
    int            h;
    int            nch;
    int            r;
    int            c;
    int            acc;
    pixel_t        above;
    pixel_t        beside;
    chans_t        vals;
    sharp_result_t batch [$];
    w   = clamp_dim(cfg_width, LINE_DEPTH);
    h   = clamp_dim(cfg_height, ROWS_MAX);
    nch = (cfg_chans > NUM_CHAN) ? NUM_CHAN : cfg_chans;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= h) begin
      cur_row = 0;
    end
    r      = cur_row;
    c      = cur_col;
    above  = older_row[c];
    beside = newer_row[c];
    if (r >= 1 && c >= 1) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        if (r < 2 || c < 2 || k >= nch) begin
          vals[k] = '0;
        end else begin
          acc = 5 * int'(win_px[1][k*CHAN_W +: CHAN_W])
              - int'(win_px[4][k*CHAN_W +: CHAN_W])
              - int'(beside[k*CHAN_W +: CHAN_W])
              - int'(win_px[0][k*CHAN_W +: CHAN_W])
              - int'(win_px[2][k*CHAN_W +: CHAN_W]);
          vals[k] = (acc < 0) ? '0 : ((acc > 255) ? '1 : CHAN_W'(acc));
        end
      end
      batch.push_back(make_result(r - 1, c - 1, vals));
      if (c == w - 1) begin
        batch.push_back(make_result(r - 1, w - 1, '0));
      end
      if (r == h - 1) begin
        batch.push_back(make_result(h - 1, c - 1, '0));
        if (c == w - 1) begin
          batch.push_back(make_result(h - 1, w - 1, '0));
        end
      end
      batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) begin
        sharpened_q.push_back(batch[i]);
      end
    end
    win_px[3] = win_px[0];
    win_px[4] = win_px[1];
    win_px[5] = win_px[2];
    win_px[0] = above;
    win_px[1] = beside;
    win_px[2] = px;
    older_row[c] = beside;
    newer_row[c] = px;
    cur_col = c + 1;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row = r + 1;
      if (cur_row >= h) begin
        cur_row = 0;
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    sharp_result_t want;
    if (rst) begin
      foreach (older_row[i]) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      foreach (win_px[i]) begin
        win_px[i] = '0;
      end
      cur_row     = 0;
      cur_col     = 0;
      cfg_width   = 640;
      cfg_height  = 480;
      cfg_chans   = 1;
      sharpened_q.delete();
      failures    = 0;
      pixels_seen = 0;
      queued      = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            cfg_width = int'(cfg_data[CFG_WIDTH_W-1:0]);
          end
          REG_IMAGE_HEIGHT: begin
            cfg_height = int'(cfg_data[CFG_HEIGHT_W-1:0]);
          end
          REG_CHANNEL_COUNT: begin
            cfg_chans = int'(cfg_data[CFG_CHAN_W-1:0]);
          end
          default: begin
          end
        endcase
      end
      if (pix.valid && pix.ready) begin
        predict_pixel({pix.chan_d, pix.chan_c, pix.chan_b, pix.chan_a});
        pixels_seen++;
      end
      if (res.valid && res.ready) begin
        if (sharpened_q.size() == 0) begin
          $error("result transaction for row %0d col %0d with nothing expected",
                 res.out_row, res.out_col);
          failures++;
        end else begin
          want = sharpened_q.pop_front();
          check_field("res_a", want.chans[0], res.res_a);
          check_field("res_b", want.chans[1], res.res_b);
          check_field("res_c", want.chans[2], res.res_c);
          check_field("res_d", want.chans[3], res.res_d);
          check_field("out_row", want.row, res.out_row);
          check_field("out_col", want.col, res.out_col);
          check_field("run_end", want.last, res.run_end);
        end
      end
      queued = sharpened_q.size();
    end
  end

endmodule

// ===== bench/tb_sharpen_3x3_filter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sharpen_3x3_filter: stimulus and verdict for the 3x3 sharpen filter
// Drives pixel transactions frame by frame under changing geometry and
// channel settings, including a shrink of the frame part-way through and
// out-of-range register values, with random gaps on both channels, one
// stretch without gaps and one long hold on the result side. A checker
// beside the block predicts and compares the results.
// ---------------------------------------------------------------------------
module tb_sharpen_3x3_filter;
  import shp_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 150;
  localparam int HOLD_CYCLES   = 400;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    failures;
  int                    pixels_seen;
  int                    queued;
  int                    pixels_sent;
  int                    trk_row;
  int                    trk_col;
  int                    trk_w;
  int                    trk_h;
  bit                    calm;
  int                    squeeze_req;
  int                    squeeze_done;
  int                    hold_left;

  pixel_t directed_px [0:14] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h8040_2010, 32'hFFFF_FFFF, 32'h7F3C_C301
  };

  shp_in_if  pix_if ();
  shp_out_if res_if ();

  sharpen_3x3_filter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix_if),
    .results   (res_if)
  );

  sharpen_result_checker sharpen_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pix         (pix_if),
    .res         (res_if),
    .failures    (failures),
    .pixels_seen (pixels_seen),
    .queued      (queued)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_sharpen_3x3_filter: FAIL");
    $finish;
  end

  // Result side: random stalls, none while calm, and a long hold on request.
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
      squeeze_done <= 0;
    end else if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (squeeze_done != squeeze_req) begin
      res_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      squeeze_done <= squeeze_done + 1;
    end else if (calm) begin
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= 35);
    end
  end

  function automatic int clamp_dim(int v, int hi);
    return (v < 3) ? 3 : ((v > hi) ? hi : v);
  endfunction

  // Pixels still needed to bring the raster position back to the start of a
  // frame; a position beyond the frame wraps to row 0 first.
  function automatic int frame_remaining();
    int ew;
    int eh;
    int r;
    int c;
    ew = clamp_dim(trk_w, 2048);
    eh = clamp_dim(trk_h, 4096);
    r  = trk_row;
    c  = trk_col;
    if (r == 0 && c == 0) begin
      return 0;
    end
    if (c >= ew) begin
      c = 0;
      r++;
    end
    if (r >= eh) begin
      r = 0;
    end
    return (eh - r) * ew - c;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p = $urandom;
    for (int k = 0; k < NUM_CHAN; k++) begin
      case ($urandom_range(7))
        0: p[k*CHAN_W +: CHAN_W] = '0;
        1: p[k*CHAN_W +: CHAN_W] = '1;
        default: begin
        end
      endcase
    end
    return p;
  endfunction

  task automatic step_raster();
    int ew;
    int eh;
    ew = clamp_dim(trk_w, 2048);
    eh = clamp_dim(trk_h, 4096);
    if (trk_col >= ew) begin
      trk_col = 0;
      trk_row++;
    end
    if (trk_row >= eh) begin
      trk_row = 0;
    end
    trk_col++;
    if (trk_col >= ew) begin
      trk_col = 0;
      trk_row++;
      if (trk_row >= eh) begin
        trk_row = 0;
      end
    end
  endtask

  task automatic push_pixel(input pixel_t px);
    while (!calm && $urandom_range(99) < 35) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid  <= 1'b1;
    pix_if.chan_a <= px[7:0];
    pix_if.chan_b <= px[15:8];
    pix_if.chan_c <= px[23:16];
    pix_if.chan_d <= px[31:24];
    do @(posedge clk); while (!pix_if.ready);
    pixels_sent++;
    step_raster();
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) begin
      push_pixel(random_pixel());
    end
  endtask

  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (pixels_seen != pixels_sent || queued != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input int w, input int h, input int ch);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_data  <= CFG_DATA_W'(ch);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    trk_w = w;
    trk_h = h;
  endtask

  initial begin
    int random_count;
    int w;
    int h;
    int n;
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= REG_IMAGE_WIDTH;
    cfg_data      <= '0;
    pix_if.valid  <= 1'b0;
    pix_if.chan_a <= '0;
    pix_if.chan_b <= '0;
    pix_if.chan_c <= '0;
    pix_if.chan_d <= '0;
    calm          = 1'b0;
    squeeze_req   = 0;
    pixels_sent   = 0;
    random_count  = 0;
    trk_row       = 0;
    trk_col       = 0;
    trk_w         = 640;
    trk_h         = 480;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // A few pixels at the reset geometry, then the frame is shrunk under them.
    push_pixel(32'h0000_0000);
    push_pixel(32'hFFFF_FFFF);
    push_pixel(32'hA5A5_A5A5);
    push_pixel(32'h5A5A_5A5A);
    push_pixel(32'h0102_0408);
    wait_idle();
    program_regs(3, 3, 4);
    for (int i = 0; i < 15; i++) begin
      push_pixel(directed_px[i]);
    end
    wait_idle();

    while (random_count < RANDOM_ITEMS) begin
      w = ($urandom_range(7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      h = ($urandom_range(7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 5);
      program_regs(w, h, $urandom_range(0, 7));
      if ($urandom_range(2) == 0) begin
        n = $urandom_range(1, clamp_dim(w, 2048) * clamp_dim(h, 4096) - 1);
        send_random(n);
        random_count += n;
        wait_idle();
        program_regs($urandom_range(0, clamp_dim(w, 2048)),
                     $urandom_range(0, clamp_dim(h, 4096)), $urandom_range(0, 7));
        n = frame_remaining();
      end else begin
        n = $urandom_range(1, 2) * clamp_dim(w, 2048) * clamp_dim(h, 4096);
      end
      send_random(n);
      random_count += n;
      wait_idle();
    end

    calm = 1'b1;
    program_regs(10, 5, 4);
    send_random(10 * 5);
    wait_idle();
    calm = 1'b0;

    program_regs(8, 4, 3);
    squeeze_req++;
    send_random(8 * 4);
    wait_idle();

    program_regs(2, 8191, 5);
    send_random(3 * 10);
    wait_idle();

    if (failures == 0) begin
      $display("tb_sharpen_3x3_filter: PASS");
    end else begin
      $display("tb_sharpen_3x3_filter: FAIL");
    end
    $finish;
  end

endmodule
